// ----- src/tcw_pkg.sv -----
// tcw_pkg: shared constants, field widths and controller/datapath structs
// for the text console writer. No dependencies.

package tcw_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  localparam int MODE_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  localparam int COLOR_W   = 8;
  localparam int CELL_W    = CHAR_W + COLOR_W;

  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [CHAR_W-1:0]  SPACE_CHAR       = 8'h20;
  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR     = 8'h0A;
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h0F;

  // controller -> datapath
  typedef struct packed {
    logic capture;        // latch request fields
    logic sweep_all;      // sweep pointer to first cell
    logic sweep_copy;     // sweep pointer to first cell of row 1
    logic sweep_last_row; // sweep pointer to first cell of bottom row
    logic fill_step;      // write a blank at sweep pointer, advance
    logic copy_read;      // read at sweep pointer for scroll, advance
    logic newline;        // column to 0, row up unless on last row
    logic write_char;     // write character at cursor, advance column
    logic read_cell;      // read cell chosen by the request
    logic load_result;    // load output register
  } tcw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              is_newline;
    logic              line_full;
    logic              last_row;
    logic              sweep_done;
  } tcw_stat_t;

endpackage

// ----- src/tcw_if.sv -----
// tcw_if: valid/ready channel interfaces for requests and results.
// Depends on tcw_pkg for field widths.

interface tcw_req_if import tcw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [CHAR_W-1:0]  character;
  logic [INDEX_W-1:0] cell_index;

  modport source (output valid, mode, character, cell_index, input ready);
  modport sink (input valid, mode, character, cell_index, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ROW_OUT_W-1:0] cursor_row_out;
  logic [COL_OUT_W-1:0] cursor_column_out;
  logic [CHAR_W-1:0]    cell_character;
  logic [COLOR_W-1:0]   cell_color;

  modport source (output valid, cursor_row_out, cursor_column_out, cell_character,
                  cell_color, input ready);
  modport sink (input valid, cursor_row_out, cursor_column_out, cell_character,
                cell_color, output ready);
endinterface

// ----- src/tcw_ctrl.sv -----
// tcw_ctrl: sequencing state machine for the text console writer.
// Depends on tcw_pkg (command and status structs, mode codes).

module tcw_ctrl import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output tcw_cmd_t  cmd,
  input  tcw_stat_t stat
);

  typedef enum logic [9:0] {
    S_INIT         = 10'b00_0000_0001,
    S_IDLE         = 10'b00_0000_0010,
    S_DECODE       = 10'b00_0000_0100,
    S_WRITE        = 10'b00_0000_1000,
    S_READ         = 10'b00_0001_0000,
    S_FILL         = 10'b00_0010_0000,
    S_SCROLL_COPY  = 10'b00_0100_0000,
    S_SCROLL_FLUSH = 10'b00_1000_0000,
    S_SCROLL_FILL  = 10'b01_0000_0000,
    S_DONE         = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    req_ready      = 1'b0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    unique case (state)
      S_INIT: begin
        cmd.fill_step = 1'b1;
        if (stat.sweep_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.mode)
          MODE_PUT: begin
            if (stat.is_newline || stat.line_full) begin
              cmd.newline = 1'b1;
              if (stat.last_row) begin
                cmd.sweep_copy = 1'b1;
                state_next     = S_SCROLL_COPY;
              end else begin
                state_next = stat.is_newline ? S_DONE : S_WRITE;
              end
            end else begin
              state_next = S_WRITE;
            end
          end
          MODE_CLEAR: begin
            cmd.sweep_all = 1'b1;
            state_next    = S_FILL;
          end
          MODE_READ: state_next = S_READ;
          default:   state_next = S_DONE;
        endcase
      end
      S_WRITE: begin
        cmd.write_char = 1'b1;
        state_next     = S_DONE;
      end
      S_READ: begin
        cmd.read_cell = 1'b1;
        state_next    = S_DONE;
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.sweep_done) state_next = S_DONE;
      end
      S_SCROLL_COPY: begin
        cmd.copy_read = 1'b1;
        if (stat.sweep_done) state_next = S_SCROLL_FLUSH;
      end
      S_SCROLL_FLUSH: begin
        // last copied cell is written back this cycle
        cmd.sweep_last_row = 1'b1;
        state_next         = S_SCROLL_FILL;
      end
      S_SCROLL_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.sweep_done) state_next = stat.is_newline ? S_DONE : S_WRITE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_result = 1'b1;
          rsp_valid_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_valid) |=> state == S_DECODE)
    else $error("accepted request not decoded");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("result raised outside completion");

  a_write_not_full: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |-> !stat.line_full)
    else $error("character write on a full line");

  a_scroll_last_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECODE && state_next == S_SCROLL_COPY) |-> stat.last_row)
    else $error("scroll started away from last row");
`endif

endmodule

// ----- src/tcw_dp.sv -----
// tcw_dp: cell store, cursor, sweep pointer and result register of the
// text console writer. Depends on tcw_pkg (widths, constants, structs).

module tcw_dp import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [COLOR_W-1:0]   cfg_wr_data,
  input  logic [MODE_W-1:0]    req_mode,
  input  logic [CHAR_W-1:0]    req_character,
  input  logic [INDEX_W-1:0]   req_cell_index,
  input  tcw_cmd_t             cmd,
  output tcw_stat_t            stat,
  output logic [ROW_OUT_W-1:0] cursor_row_out,
  output logic [COL_OUT_W-1:0] cursor_column_out,
  output logic [CHAR_W-1:0]    cell_character,
  output logic [COLOR_W-1:0]   cell_color
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int RW         = $clog2(ROWS);
  localparam int CW         = $clog2(COLUMNS + 1);

  logic [CELL_W-1:0] mem [CELL_COUNT];

  logic [COLOR_W-1:0] text_color;
  logic [COLOR_W-1:0] fill_color;
  logic [MODE_W-1:0]  item_mode;
  logic [CHAR_W-1:0]  item_char;
  logic [INDEX_W-1:0] item_index;
  logic [RW-1:0]      cursor_row;
  logic [CW-1:0]      cursor_col;
  logic [AW-1:0]      sweep;
  logic               copy_valid;
  logic [AW-1:0]      copy_dst;
  logic [CELL_W-1:0]  rd_data;

  logic [31:0]        index_ext;
  logic               in_range;
  logic [AW-1:0]      char_addr;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;

  assign index_ext = 32'(item_index);
  assign in_range  = index_ext < 32'(CELL_COUNT);
  assign char_addr = AW'(int'(cursor_row) * COLUMNS + int'(cursor_col));

  assign stat.mode       = item_mode;
  assign stat.is_newline = item_char == NEWLINE_CHAR;
  assign stat.line_full  = cursor_col >= CW'(COLUMNS);
  assign stat.last_row   = cursor_row == RW'(ROWS - 1);
  assign stat.sweep_done = sweep == AW'(CELL_COUNT - 1);

  // single write port: pending scroll copy, blank fill, or character
  always_comb begin
    mem_we    = 1'b1;
    mem_waddr = char_addr;
    mem_wdata = {text_color, item_char};
    priority if (copy_valid) begin
      mem_waddr = copy_dst;
      mem_wdata = rd_data;
    end else if (cmd.fill_step) begin
      mem_waddr = sweep;
      mem_wdata = {fill_color, SPACE_CHAR};
    end else if (cmd.write_char) begin
      mem_waddr = char_addr;
    end else begin
      mem_we = 1'b0;
    end
  end

  assign mem_re    = cmd.copy_read || cmd.read_cell;
  assign mem_raddr = cmd.copy_read ? sweep : index_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= TEXT_COLOR_RESET;
      fill_color <= TEXT_COLOR_RESET;
      cursor_row <= '0;
      cursor_col <= '0;
      sweep      <= '0;
      copy_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) text_color <= cfg_wr_data;
      if (cmd.capture) fill_color <= text_color;

      if (cmd.newline) begin
        cursor_col <= '0;
        if (!stat.last_row) cursor_row <= cursor_row + 1'b1;
      end else if (cmd.write_char) begin
        cursor_col <= cursor_col + 1'b1;
      end

      priority if (cmd.sweep_all) sweep <= '0;
      else if (cmd.sweep_copy) sweep <= AW'(COLUMNS);
      else if (cmd.sweep_last_row) sweep <= AW'((ROWS - 1) * COLUMNS);
      else if (cmd.fill_step || cmd.copy_read) sweep <= sweep + 1'b1;

      copy_valid <= cmd.copy_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode  <= req_mode;
      item_char  <= req_character;
      item_index <= req_cell_index;
    end
    if (cmd.copy_read) copy_dst <= sweep - AW'(COLUMNS);
    if (cmd.load_result) begin
      cursor_row_out    <= ROW_OUT_W'(cursor_row);
      cursor_column_out <= COL_OUT_W'(cursor_col);
      if (item_mode == MODE_READ && in_range) begin
        cell_character <= rd_data[CHAR_W-1:0];
        cell_color     <= rd_data[CELL_W-1:CHAR_W];
      end else begin
        cell_character <= '0;
        cell_color     <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    cursor_col <= CW'(COLUMNS))
    else $error("cursor column beyond line length");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    cursor_row <= RW'(ROWS - 1))
    else $error("cursor row beyond last row");

  a_write_port: assert property (@(posedge clk) disable iff (rst)
    copy_valid |-> !cmd.fill_step && !cmd.write_char)
    else $error("write port contention during scroll");
`endif

endmodule

// ----- src/text_console_writer.sv -----
// text_console_writer: top level of the character console; joins the
// controller and datapath. Depends on tcw_pkg, tcw_if, tcw_ctrl, tcw_dp.
//
//   channel   dir  signals                                         note
//   request   in   valid ready mode character cell_index           one request
//   result    out  valid ready cursor_row_out cursor_column_out    one per request
//                  cell_character cell_color
//   config    in   cfg_wr_en cfg_wr_data                           text_color
//
// Every request passes a decode step and a final step that loads the result.
// A scroll adds a copy pass over rows 1 to ROWS-1 and a fill pass over the
// bottom row, bound by the single write port of the cell store.
// After reset a clearing pass blanks the store, and request.ready stays
// low through it.
// A result waiting in the output register does not block the next request;
// that request completes its work and holds in its final step until the
// output register frees.

module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  tcw_req_if.sink            request,
  tcw_rsp_if.source          result,
  input  logic               cfg_wr_en,
  input  logic [COLOR_W-1:0] cfg_wr_data
);

  tcw_cmd_t  cmd;
  tcw_stat_t stat;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .rsp_valid (result.valid),
    .rsp_ready (result.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .req_mode          (request.mode),
    .req_character     (request.character),
    .req_cell_index    (request.cell_index),
    .cmd               (cmd),
    .stat              (stat),
    .cursor_row_out    (result.cursor_row_out),
    .cursor_column_out (result.cursor_column_out),
    .cell_character    (result.cell_character),
    .cell_color        (result.cell_color)
  );

endmodule
